// ===== sv/ldg_pkg.sv =====
// ----------------------------------------------------------------------------
// ldg_pkg
// Widths and shared types of the line dash generator.
// ----------------------------------------------------------------------------
package ldg_pkg;

  localparam int COORD_W = 24;
  localparam int CFG_W   = 23;
  localparam int ABS_W   = 24;
  localparam int LEN_W   = 25;
  localparam int PROD_W  = 50;
  localparam int SU_W    = 28;

  localparam logic REG_DASH = 1'b0;
  localparam logic REG_GAP  = 1'b1;

  typedef struct packed {
    logic                      trunc;
    logic                      last;
    logic [COORD_W-1:0]        ey;
    logic [COORD_W-1:0]        ex;
    logic [COORD_W-1:0]        sy;
    logic [COORD_W-1:0]        sx;
  } ldg_res_t;

endpackage

// ===== sv/ldg_cmp_sub.sv =====
// ----------------------------------------------------------------------------
// ldg_cmp_sub
// Shared compare and subtract step for the root and divide iterations.
// ----------------------------------------------------------------------------
module ldg_cmp_sub import ldg_pkg::*; (
  input  logic [SU_W-1:0] a_i,
  input  logic [SU_W-1:0] b_i,
  output logic [SU_W-1:0] diff_o,
  output logic            ge_o
);

  assign diff_o = a_i - b_i;
  assign ge_o   = (a_i >= b_i);

endmodule

// ===== sv/ldg_core.sv =====
// ----------------------------------------------------------------------------
// ldg_core
// Sequencer and datapath: squares, bitwise root, then per dash four
// multiply-divide interpolations on one shared compare/subtract unit.
// ----------------------------------------------------------------------------
module ldg_core import ldg_pkg::*; #(
  parameter int MAX_DASHES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] ax_i,
  input  logic [COORD_W-1:0] ay_i,
  input  logic [COORD_W-1:0] bx_i,
  input  logic [COORD_W-1:0] by_i,
  input  logic [CFG_W-1:0]   dash_i,
  input  logic [CFG_W-1:0]   gap_i,
  output logic               res_valid_o,
  output ldg_res_t           res_o,
  input  logic               res_free_i
);

  localparam int KW = (MAX_DASHES > 1) ? $clog2(MAX_DASHES) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_SUM  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_LEN  = 4'd5;
  localparam logic [3:0] S_DASH = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_DVI  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_FIX  = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;

  logic [3:0]         state_q, state_d;
  logic [4:0]         cnt_q;
  logic [1:0]         lidx_q;
  logic [KW-1:0]      k_q;
  logic               pass_q;
  logic [COORD_W-1:0] ax_q, ay_q;
  logic [ABS_W-1:0]   udx_q, udy_q;
  logic               ndx_q, ndy_q;
  logic [PROD_W-1:0]  prod_q, rad_q;
  logic [SU_W-1:0]    rem_q;
  logic [LEN_W-1:0]   root_q, len_q, t_q, e_q;
  logic [LEN_W:0]     nt_q;
  logic [COORD_W-1:0] rsx_q, rsy_q, rex_q, rey_q;

  logic [LEN_W:0]     period, nt, e_raw;
  logic [LEN_W:0]     dx_w, dy_w;
  logic [ABS_W-1:0]   mul_a;
  logic [LEN_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [SU_W-1:0]    su_a, su_b, su_diff;
  logic               su_ge;
  logic [COORD_W-1:0] base, qv, coord;
  logic               neg, more, at_max;

  assign period = (LEN_W+1)'(dash_i) + (LEN_W+1)'(gap_i);
  assign dx_w   = (LEN_W+1)'(signed'(bx_i)) - (LEN_W+1)'(signed'(ax_i));
  assign dy_w   = (LEN_W+1)'(signed'(by_i)) - (LEN_W+1)'(signed'(ay_i));
  assign nt     = (LEN_W+1)'(t_q) + period;
  assign e_raw  = (LEN_W+1)'(t_q) + (LEN_W+1)'(dash_i);

  always_comb begin
    mul_a = udx_q;
    mul_b = LEN_W'(udx_q);
    unique case (state_q)
      S_SQY:   begin
        mul_a = udy_q;
        mul_b = LEN_W'(udy_q);
      end
      S_MUL:   begin
        mul_a = lidx_q[0] ? udy_q : udx_q;
        mul_b = lidx_q[1] ? e_q : t_q;
      end
      default: begin
        mul_a = udx_q;
        mul_b = LEN_W'(udx_q);
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    if (state_q == S_SQRT) begin
      su_a = {rem_q[SU_W-3:0], rad_q[PROD_W-1 -: 2]};
      su_b = {1'b0, root_q, 2'b01};
    end else begin
      su_a = {2'b00, rem_q[LEN_W-1:0], prod_q[PROD_W-1]};
      su_b = SU_W'(len_q);
    end
  end

  ldg_cmp_sub u_cmp_sub (
    .a_i    (su_a),
    .b_i    (su_b),
    .diff_o (su_diff),
    .ge_o   (su_ge)
  );

  assign base   = lidx_q[0] ? ay_q : ax_q;
  assign neg    = lidx_q[0] ? ndy_q : ndx_q;
  assign qv     = root_q[COORD_W-1:0];
  assign coord  = neg ? (base - qv) : (base + qv);
  assign more   = (nt_q < (LEN_W+1)'(len_q));
  assign at_max = (k_q == KW'(MAX_DASHES - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = (period == '0) ? S_EMIT : S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_SUM;
      S_SUM:  state_d = S_SQRT;
      S_SQRT: if (cnt_q == '0) state_d = S_LEN;
      S_LEN:  state_d = (root_q == '0) ? S_IDLE : S_DASH;
      S_DASH: state_d = S_MUL;
      S_MUL:  state_d = S_DVI;
      S_DVI:  state_d = S_DIV;
      S_DIV:  if (cnt_q == '0) state_d = S_FIX;
      S_FIX:  state_d = (lidx_q == 2'd3) ? S_EMIT : S_MUL;
      S_EMIT: begin
        if (res_free_i) state_d = (pass_q || !more || at_max) ? S_IDLE : S_DASH;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      lidx_q  <= '0;
      k_q     <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pass_q <= (period == '0);
            k_q    <= '0;
          end
        end
        S_SUM:  cnt_q <= 5'(LEN_W - 1);
        S_SQRT: cnt_q <= cnt_q - 5'd1;
        S_DASH: lidx_q <= '0;
        S_DVI:  cnt_q <= 5'(LEN_W - 1);
        S_DIV:  cnt_q <= cnt_q - 5'd1;
        S_FIX:  lidx_q <= lidx_q + 2'd1;
        S_EMIT: if (res_free_i) k_q <= k_q + KW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        ax_q  <= ax_i;
        ay_q  <= ay_i;
        ndx_q <= dx_w[LEN_W];
        ndy_q <= dy_w[LEN_W];
        udx_q <= ABS_W'(dx_w[LEN_W] ? -dx_w : dx_w);
        udy_q <= ABS_W'(dy_w[LEN_W] ? -dy_w : dy_w);
        rsx_q <= ax_i;
        rsy_q <= ay_i;
        rex_q <= bx_i;
        rey_q <= by_i;
      end
      S_SQX: prod_q <= mul_p;
      S_SQY: begin
        rad_q  <= prod_q;
        prod_q <= mul_p;
      end
      S_SUM: begin
        rad_q  <= rad_q + prod_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      S_SQRT: begin
        rad_q  <= {rad_q[PROD_W-3:0], 2'b00};
        rem_q  <= su_ge ? su_diff : su_a;
        root_q <= {root_q[LEN_W-2:0], su_ge};
      end
      S_LEN: begin
        len_q <= root_q;
        t_q   <= '0;
      end
      S_DASH: begin
        nt_q <= nt;
        e_q  <= (e_raw > (LEN_W+1)'(len_q)) ? len_q : LEN_W'(e_raw);
      end
      S_MUL: prod_q <= mul_p;
      S_DVI: begin
        rem_q  <= SU_W'(prod_q[PROD_W-1:LEN_W]);
        prod_q <= {prod_q[LEN_W-1:0], {(PROD_W-LEN_W){1'b0}}};
        root_q <= '0;
      end
      S_DIV: begin
        rem_q  <= su_ge ? su_diff : su_a;
        prod_q <= {prod_q[PROD_W-2:0], 1'b0};
        root_q <= {root_q[LEN_W-2:0], su_ge};
      end
      S_FIX: begin
        unique case (lidx_q)
          2'd0: rsx_q <= coord;
          2'd1: rsy_q <= coord;
          2'd2: rex_q <= coord;
          2'd3: rey_q <= coord;
          default: rsx_q <= coord;
        endcase
      end
      S_EMIT: if (res_free_i && more) t_q <= LEN_W'(nt_q);
      default: rem_q <= rem_q;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);
  assign res_o.sx    = rsx_q;
  assign res_o.sy    = rsy_q;
  assign res_o.ex    = rex_q;
  assign res_o.ey    = rey_q;
  assign res_o.last  = pass_q || !more || at_max;
  assign res_o.trunc = !pass_q && more && at_max;

endmodule

// ===== sv/line_dash_generator_top.sv =====
// ----------------------------------------------------------------------------
// line_dash_generator_top
// Splits one segment per input word into dash words on a stream interface.
// Flow: a zero period gives its segment back as one word; else the squares
// and the 25-step root, then per dash four 25-step divides on the shared
// compare/subtract unit.
// Throughput: one segment at a time; tready is high only when idle.
// Reset: async active low; clears sequencer, output valid and the dash/gap registers to 0.
// ----------------------------------------------------------------------------
module line_dash_generator_top import ldg_pkg::*; #(
  parameter int MAX_DASHES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [4*COORD_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // dash_start_x, dash_start_y, dash_end_x, dash_end_y
  output logic [4*COORD_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,
  // truncated
  output logic                 m_axis_tuser
);

  logic [CFG_W-1:0] dash_q, gap_q;
  logic             res_valid, res_free, out_valid_q;
  ldg_res_t         res, out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_q <= '0;
      gap_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DASH: dash_q <= cfg_data_i;
        REG_GAP:  gap_q  <= cfg_data_i;
        default:  dash_q <= dash_q;
      endcase
    end
  end

  ldg_core #(
    .MAX_DASHES (MAX_DASHES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .ax_i        (s_axis_tdata[COORD_W-1:0]),
    .ay_i        (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .bx_i        (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
    .by_i        (s_axis_tdata[4*COORD_W-1:3*COORD_W]),
    .dash_i      (dash_q),
    .gap_i       (gap_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  assign res_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.ey, out_q.ex, out_q.sy, out_q.sx};
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = out_q.trunc;

endmodule

// ===== sv/ldg_checker.sv =====
// ----------------------------------------------------------------------------
// ldg_checker
// Port-level checks of the line dash generator, bound to the top level.
// ----------------------------------------------------------------------------
module ldg_checker import ldg_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [4*COORD_W-1:0] s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [4*COORD_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast,
  input logic                 m_axis_tuser
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("tready high right after an accepted word");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> $stable(s_axis_tdata))
    else $error("input word changed while waiting");

  a_trunc_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("truncated flag without last");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped or changed while stalled");

endmodule

bind line_dash_generator_top ldg_checker u_ldg_checker (.*);

// ===== tb/line_dash_generator_top_tb.sv =====
// ----------------------------------------------------------------------------
// line_dash_generator_top_tb
// Self-checking bench for the line dash generator: a directed table of
// segments, then random segments under random stalls on both streams, checked
// word by word against a local dash predictor across several dash/gap settings.
// ----------------------------------------------------------------------------
module line_dash_generator_top_tb import ldg_pkg::*; ();

  localparam int MAXD = 64;
  localparam int WDOG = 200000;
  localparam int NDIR = 14;

  typedef struct packed {
    logic signed [COORD_W-1:0] ey;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] sx;
  } seg_t;

  typedef struct {
    seg_t             seg;
    logic [CFG_W-1:0] dash;
    logic [CFG_W-1:0] gap;
    bit               chk;
    logic             l0;
    logic             t0;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic cfg_ready_o;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [4*COORD_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [4*COORD_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  line_dash_generator_top #(.MAX_DASHES(MAXD)) dut (.*);

  always #6 clk_i = ~clk_i;

  logic [CFG_W-1:0] dash_len, gap_len;
  ldg_res_t dash_q[$];
  int errors = 0;
  int idle_cnt = 0;
  bit hold_rx = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] interp(longint a, longint d, longint t, longint n);
    longint p;
    p = a + (d * t) / n;
    return p[COORD_W-1:0];
  endfunction

  task automatic predict_dashes(seg_t s);
    longint ax, ay, dx, dy, per, n, t, e, ux, uy;
    int k;
    ldg_res_t r;
    ax = longint'(s.sx);
    ay = longint'(s.sy);
    dx = longint'(s.ex) - ax;
    dy = longint'(s.ey) - ay;
    per = longint'(dash_len) + longint'(gap_len);
    if (per == 0) begin
      r = '{trunc: 1'b0, last: 1'b1, ey: s.ey, ex: s.ex, sy: s.sy, sx: s.sx};
      dash_q.insert(dash_q.size(), r);
      return;
    end
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    n = longint'(isqrt(ux * ux + uy * uy));
    if (n == 0) return;
    k = 0;
    for (t = 0; t < n; t += per) begin
      if (k >= MAXD) begin
        dash_q[$].trunc = 1'b1;
        break;
      end
      e = t + longint'(dash_len);
      if (e > n) e = n;
      r.sx = interp(ax, dx, t, n);
      r.sy = interp(ay, dy, t, n);
      r.ex = interp(ax, dx, e, n);
      r.ey = interp(ay, dy, e, n);
      r.last = 1'b0;
      r.trunc = 1'b0;
      dash_q.insert(dash_q.size(), r);
      k++;
    end
    dash_q[$].last = 1'b1;
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_DASH) dash_len = val; else gap_len = val;
  endtask

  task automatic set_pattern(logic [CFG_W-1:0] d, logic [CFG_W-1:0] g);
    wait (dash_q.size() == 0);
    repeat (MAXD * 120 + 200) @(posedge clk_i);
    write_reg(REG_DASH, d);
    write_reg(REG_GAP, g);
  endtask

  task automatic send_seg(seg_t s, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 10) : 0;
    repeat (w) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_dashes(s);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [COORD_W-1:0] rcoord(int mode);
    logic [COORD_W-1:0] c;
    case (mode)
      0: c = COORD_W'($urandom);
      1: c = COORD_W'($urandom_range(0, 8191) - 4096);
      default: c = COORD_W'($urandom_range(0, 1023));
    endcase
    return c;
  endfunction

  function automatic seg_t rseg();
    seg_t s;
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) begin
      s.sx = rcoord(1);
      s.sy = rcoord(1);
      s.ex = s.sx + rcoord(2) - COORD_W'(512);
      s.ey = s.sy + rcoord(2) - COORD_W'(512);
    end else if (m < 9) begin
      s.sx = rcoord(0);
      s.sy = rcoord(0);
      s.ex = rcoord(0);
      s.ey = rcoord(0);
    end else begin
      s.sx = rcoord(1);
      s.sy = rcoord(1);
      s.ex = s.sx;
      s.ey = s.sy;
    end
    return s;
  endfunction

  // receiver
  initial begin
    int w;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        wait (!hold_rx);
      end
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      m_axis_tready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    ldg_res_t exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (dash_q.size() == 0) begin
        $error("unexpected word %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = dash_q.pop_front();
        if (m_axis_tdata[23:0] !== exp_r.sx) begin
          $error("dash_start_x exp %h got %h", exp_r.sx, m_axis_tdata[23:0]); errors++;
        end
        if (m_axis_tdata[47:24] !== exp_r.sy) begin
          $error("dash_start_y exp %h got %h", exp_r.sy, m_axis_tdata[47:24]); errors++;
        end
        if (m_axis_tdata[71:48] !== exp_r.ex) begin
          $error("dash_end_x exp %h got %h", exp_r.ex, m_axis_tdata[71:48]); errors++;
        end
        if (m_axis_tdata[95:72] !== exp_r.ey) begin
          $error("dash_end_y exp %h got %h", exp_r.ey, m_axis_tdata[95:72]); errors++;
        end
        if (m_axis_tlast !== exp_r.last) begin
          $error("last_dash exp %b got %b", exp_r.last, m_axis_tlast); errors++;
        end
        if (m_axis_tuser !== exp_r.trunc) begin
          $error("truncated exp %b got %b", exp_r.trunc, m_axis_tuser); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  row_t dir [NDIR];

  initial begin
    ldg_res_t r;
    dash_len = '0;
    gap_len = '0;
    // zero period after reset: passthrough, even for zero length
    dir = '{
      '{'{ey: 24'h7FFFFF, ex: 24'h7FFFFF, sy: 24'h800000, sx: 24'h800000},
        23'd0, 23'd0, 1'b1, 1'b1, 1'b0},
      '{'{ey: 24'h000010, ex: 24'h000010, sy: 24'h000010, sx: 24'h000010},
        23'd0, 23'd0, 1'b1, 1'b1, 1'b0},
      '{'{ey: 24'h800000, ex: 24'h7FFFFF, sy: 24'h7FFFFF, sx: 24'h800000},
        23'd0, 23'd0, 1'b1, 1'b1, 1'b0},
      '{'{ey: 24'h000000, ex: 24'h000800, sy: 24'h000000, sx: 24'h000000},
        23'd256, 23'd256, 1'b0, 1'b0, 1'b0},
      '{'{ey: 24'h000300, ex: 24'h000400, sy: 24'h000000, sx: 24'h000000},
        23'd256, 23'd256, 1'b0, 1'b0, 1'b0},
      '{'{ey: 24'h000005, ex: 24'h000005, sy: 24'h000005, sx: 24'h000005},
        23'd256, 23'd256, 1'b0, 1'b0, 1'b0},
      '{'{ey: 24'hFFF000, ex: 24'hFFF800, sy: 24'h000000, sx: 24'h000000},
        23'd256, 23'd256, 1'b0, 1'b0, 1'b0},
      '{'{ey: 24'h7FFFFF, ex: 24'h7FFFFF, sy: 24'h800000, sx: 24'h800000},
        23'd256, 23'd256, 1'b0, 1'b0, 1'b0},
      '{'{ey: 24'h000100, ex: 24'hFFFF00, sy: 24'h000000, sx: 24'h000000},
        23'd0, 23'd64, 1'b0, 1'b0, 1'b0},
      '{'{ey: 24'h800000, ex: 24'h800000, sy: 24'h7FFFFF, sx: 24'h7FFFFF},
        23'd0, 23'd64, 1'b0, 1'b0, 1'b0},
      '{'{ey: 24'h7FFFFF, ex: 24'h7FFFFF, sy: 24'h800000, sx: 24'h800000},
        23'h7FFFFF, 23'h7FFFFF, 1'b0, 1'b0, 1'b0},
      '{'{ey: 24'h000001, ex: 24'h000000, sy: 24'h000000, sx: 24'h000000},
        23'h7FFFFF, 23'h7FFFFF, 1'b0, 1'b0, 1'b0},
      '{'{ey: 24'h000000, ex: 24'h000100, sy: 24'h000000, sx: 24'h000000},
        23'd1, 23'd0, 1'b0, 1'b0, 1'b0},
      '{'{ey: 24'h000003, ex: 24'h000004, sy: 24'h000000, sx: 24'h000000},
        23'd1, 23'd0, 1'b0, 1'b0, 1'b0}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir[i]) begin
      if (dir[i].dash != dash_len || dir[i].gap != gap_len)
        set_pattern(dir[i].dash, dir[i].gap);
      send_seg(dir[i].seg, 1'b0);
      if (dir[i].chk) begin
        // typed word: the whole segment passes through
        dash_q.delete(dash_q.size() - 1);
        r = '{trunc: dir[i].t0, last: dir[i].l0, ey: dir[i].seg.ey, ex: dir[i].seg.ex,
              sy: dir[i].seg.sy, sx: dir[i].seg.sx};
        dash_q.insert(dash_q.size(), r);
      end
    end
    // long receiver hold-off while segments keep coming
    hold_rx = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (4) send_seg(rseg(), 1'b0);
    join
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_pattern(23'd0, 23'd0);
        1: set_pattern(CFG_W'($urandom_range(16, 512)), CFG_W'($urandom_range(16, 512)));
        2: set_pattern(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(0, 8)));
        3: set_pattern(CFG_W'($urandom_range(0, 23'h7FFFFF)),
                       CFG_W'($urandom_range(0, 23'h7FFFFF)));
        4: set_pattern(23'd0, CFG_W'($urandom_range(1, 64)));
        default: set_pattern(CFG_W'($urandom_range(64, 2048)), 23'd0);
      endcase
      for (int i = 0; i < 65; i++) begin
        send_seg(rseg(), $urandom_range(0, 4) != 0);
        if (i == 30) wait (dash_q.size() == 0);
      end
    end
    stim_done = 1'b1;
    wait (dash_q.size() == 0);
    repeat (MAXD * 120 + 200) @(posedge clk_i);
    if (errors == 0 && dash_q.size() == 0 && stim_done)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== line_dash_generator_top.f =====
sv/ldg_pkg.sv
sv/ldg_cmp_sub.sv
sv/ldg_core.sv
sv/line_dash_generator_top.sv
sv/ldg_checker.sv
tb/line_dash_generator_top_tb.sv
